FILE: design/pfh_pkg.sv
// Package for the PETSCII file name converter: state codes, character
// constants and the PETSCII-to-host character mapping functions.
// Depends on nothing.
package pfh_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_NAME,
    ST_DOT,
    ST_EXT0,
    ST_EXT1,
    ST_EXT2,
    ST_TERM
  } pfh_state_t;

  localparam logic [7:0] PAD_SPACE   = 8'h20;
  localparam logic [7:0] PAD_SHIFTED = 8'ha0;

  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_QUEST   = 8'h3f;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_PIPE    = 8'h7c;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_GT      = 8'h3e;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7e;

  localparam logic [6:0] OUT_UNDERSCORE = 7'h5f;
  localparam logic [6:0] OUT_DOT        = 7'h2e;
  localparam logic [6:0] OUT_TERM       = 7'h00;

  function automatic logic is_pad(input logic [7:0] b);
    return (b == PAD_SPACE) || (b == PAD_SHIFTED);
  endfunction

  function automatic logic [7:0] map_pet(input logic [7:0] p);
    logic [7:0] c;
    c = p;
    if (p >= 8'h41 && p <= 8'h5a) begin
      c = p + 8'h20;
    end else if (p >= 8'h60 && p <= 8'h7f) begin
      c = p + 8'h60;
    end else if (p == 8'ha0) begin
      c = 8'h20;
    end else if (p == 8'hc0) begin
      c = 8'h60;
    end else if (p >= 8'hc1 && p <= 8'hda) begin
      c = p - 8'h80;
    end else if (p >= 8'he0) begin
      c = p - 8'h40;
    end else if (p == 8'h03) begin
      c = 8'h1b;
    end else if (p == 8'h08) begin
      c = 8'h14;
    end else if (p == 8'h09) begin
      c = 8'h15;
    end else if (p == 8'h14) begin
      c = 8'h08;
    end else if (p == 8'h8d) begin
      c = 8'h0d;
    end
    return c;
  endfunction

  function automatic logic [6:0] host_char(input logic [7:0] p, input logic win);
    logic [7:0] c;
    logic       bad;
    c   = map_pet(p);
    bad = (c < PRINT_LO) || (c > PRINT_HI) || (c == CH_SLASH);
    if (win) begin
      bad = bad || (c == CH_BSLASH) || (c == CH_QUEST) || (c == CH_PERCENT) ||
            (c == CH_STAR) || (c == CH_COLON) || (c == CH_PIPE) ||
            (c == CH_QUOTE) || (c == CH_LT) || (c == CH_GT);
    end
    return bad ? OUT_UNDERSCORE : c[6:0];
  endfunction

endpackage

FILE: design/pfh_in_if.sv
// Input channel of the PETSCII file name converter: one padded name byte
// per beat, with the extension fields. Depends on nothing.
interface pfh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  name_byte;
  logic        ext_enable;
  logic [23:0] ext_chars;

  modport source(output valid, output name_byte, output ext_enable,
                 output ext_chars, input ready);
  modport sink(input valid, input name_byte, input ext_enable,
               input ext_chars, output ready);
endinterface

FILE: design/pfh_out_if.sv
// Result channel of the PETSCII file name converter: one host file name
// character per beat. Depends on nothing.
interface pfh_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source(output valid, output out_char, output out_last, input ready);
  modport sink(input valid, input out_char, input out_last, output ready);
endinterface

FILE: design/pfh_name_store.sv
// Name byte memory: one write port, one synchronous read port with a
// registered output, and write-to-read forwarding. Depends on nothing.
module pfh_name_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/petscii_filename_to_host_top.sv
// Top level of the PETSCII file name to host file name converter.
// Depends on pfh_pkg, pfh_in_if, pfh_out_if and pfh_name_store.
//
//   Channel  Direction  Beat contents
//   in_ch    in         name_byte, ext_enable, ext_chars (one name byte)
//   out_ch   out        out_char, out_last (one host character)
//   cfg_*    in         cfg_wr_data (windows_host_rules), no handshake
//
// A name loads one byte per beat. Padding is tracked as the bytes arrive,
// so the name memory is read out right after the final byte, one character
// per cycle through its single read port while out_ch is ready. A name of
// K kept bytes gives K + 1 characters, or K + 5 with an extension. Input
// is refused while a name is being emitted; the output register lets the
// next name load while the terminator waits.
// Reset is synchronous and needs no clearing pass.
module petscii_filename_to_host_top #(
  parameter int NAME_LEN = 16
) (
  input  logic clk,
  input  logic rst_n,
  pfh_in_if.sink    in_ch,
  pfh_out_if.source out_ch,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);
  import pfh_pkg::*;

  localparam int CW = $clog2(NAME_LEN + 1);
  localparam int AW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(NAME_LEN - 1);
  localparam logic [CW-1:0] LEN      = CW'(NAME_LEN);
  localparam logic [CW-1:0] ONE      = CW'(1);

  pfh_state_t state_r, state_nxt;
  logic [CW-1:0] load_cnt_r, load_cnt_nxt;
  logic [CW-1:0] lead_r, lead_nxt;
  logic [CW-1:0] trail_r, trail_nxt;
  logic          all_pad_r, all_pad_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic          ext_on_r, ext_on_nxt;
  logic [23:0]   ext_chars_r, ext_chars_nxt;
  logic          win_r;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic          byte_pad;
  logic [CW-1:0] lead_now, trail_now, first_now;
  logic          all_pad_now, ext_on_now;
  logic          out_free, load_fire;
  logic [7:0]    rd_data;
  pfh_state_t    after_name;

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign load_fire    = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.out_last = out_last_r;

  pfh_name_store #(
    .DEPTH(NAME_LEN),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (load_fire),
    .wr_addr(load_cnt_r[AW-1:0]),
    .wr_data(in_ch.name_byte),
    .rd_en  (idx_nxt < LEN),
    .rd_addr(idx_nxt[AW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    byte_pad    = is_pad(in_ch.name_byte);
    all_pad_now = all_pad_r && byte_pad;
    lead_now    = all_pad_now ? lead_r + ONE : lead_r;
    trail_now   = byte_pad ? trail_r : load_cnt_r + ONE;
    first_now   = all_pad_now ? '0 : lead_now;
    ext_on_now  = in_ch.ext_enable && (in_ch.ext_chars[23:16] != 8'h00);
    after_name  = ext_on_r ? ST_DOT : ST_TERM;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    lead_nxt      = lead_r;
    trail_nxt     = trail_r;
    all_pad_nxt   = all_pad_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    ext_on_nxt    = ext_on_r;
    ext_chars_nxt = ext_chars_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (load_cnt_r == LAST_IDX) begin
            load_cnt_nxt  = '0;
            lead_nxt      = '0;
            trail_nxt     = '0;
            all_pad_nxt   = 1'b1;
            idx_nxt       = first_now;
            end_nxt       = trail_now;
            ext_on_nxt    = ext_on_now;
            ext_chars_nxt = in_ch.ext_chars;
            if (first_now < trail_now) begin
              state_nxt = ST_NAME;
            end else if (ext_on_now) begin
              state_nxt = ST_DOT;
            end else begin
              state_nxt = ST_TERM;
            end
          end else begin
            load_cnt_nxt = load_cnt_r + ONE;
            lead_nxt     = lead_now;
            trail_nxt    = trail_now;
            all_pad_nxt  = all_pad_now;
          end
        end
      end
      ST_NAME: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = host_char(rd_data, win_r);
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r + ONE;
          if (idx_r + ONE == end_r) begin
            state_nxt = after_name;
          end
        end
      end
      ST_DOT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = OUT_DOT;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EXT0;
        end
      end
      ST_EXT0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ext_chars_r[22:16];
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EXT1;
        end
      end
      ST_EXT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ext_chars_r[14:8];
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EXT2;
        end
      end
      ST_EXT2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ext_chars_r[6:0];
          out_last_nxt  = 1'b0;
          state_nxt     = ST_TERM;
        end
      end
      ST_TERM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = OUT_TERM;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      lead_r      <= '0;
      trail_r     <= '0;
      all_pad_r   <= 1'b1;
      idx_r       <= '0;
      end_r       <= '0;
      ext_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      lead_r      <= lead_nxt;
      trail_r     <= trail_nxt;
      all_pad_r   <= all_pad_nxt;
      idx_r       <= idx_nxt;
      end_r       <= end_nxt;
      ext_on_r    <= ext_on_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ext_chars_r <= ext_chars_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

FILE: design/pfh_checker.sv
// Port-level checks for the PETSCII file name converter, and the bind that
// attaches them to petscii_filename_to_host_top. Depends on the top level.
module pfh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_char,
  input logic       out_last
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // The input is closed while a name is still being emitted.
  a_no_load_mid_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted in the middle of a name");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_char == 7'h00)
    else $error("last beat is not the terminator");

endmodule

bind petscii_filename_to_host_top pfh_checker u_pfh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_char (out_ch.out_char),
  .out_last (out_ch.out_last)
);

FILE: tb/sv/tb_pfh_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the PETSCII file name converter: watches both channels and
// the register write port, predicts each host name and compares every beat.
// Depends on pfh_pkg for the character constants.
module tb_pfh_checker #(
  parameter int NAME_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic        in_ext_enable,
  input  logic [23:0] in_ext_chars,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  out_char,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          mismatches,
  output int          chars_pending,
  output int          chars_checked
);
  import pfh_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } host_beat_t;

  host_beat_t host_chars_q[$];
  logic [7:0] name_bytes [NAME_LEN];
  int         bytes_loaded;
  logic       windows_rules;

  initial begin
    mismatches    = 0;
    chars_checked = 0;
    chars_pending = 0;
    bytes_loaded  = 0;
    windows_rules = 1'b0;
  end

  function automatic logic [7:0] petscii_to_ascii(input logic [7:0] p);
    logic [7:0] a;
    a = p;
    case (p)
      8'h03: a = 8'h1b;
      8'h08: a = 8'h14;
      8'h09: a = 8'h15;
      8'h14: a = 8'h08;
      8'h8d: a = 8'h0d;
      8'ha0: a = 8'h20;
      8'hc0: a = 8'h60;
      default: begin
        if (p >= 8'h41 && p <= 8'h5a) begin
          a = p | 8'h20;
        end else if (p >= 8'h60 && p <= 8'h7f) begin
          a = p + 8'h60;
        end else if (p >= 8'hc1 && p <= 8'hda) begin
          a = p - 8'h80;
        end else if (p >= 8'he0) begin
          a = p - 8'h40;
        end
      end
    endcase
    return a;
  endfunction

  function automatic logic [6:0] filtered_char(input logic [7:0] p, input logic win);
    logic [7:0] a;
    logic       forbidden;
    a = petscii_to_ascii(p);
    forbidden = (a == CH_SLASH);
    if (win) begin
      case (a)
        CH_BSLASH, CH_QUEST, CH_PERCENT, CH_STAR, CH_COLON,
        CH_PIPE, CH_QUOTE, CH_LT, CH_GT: forbidden = 1'b1;
        default: ;
      endcase
    end
    if (a < PRINT_LO || a > PRINT_HI || forbidden) begin
      return OUT_UNDERSCORE;
    end
    return a[6:0];
  endfunction

  function automatic logic pad_byte(input logic [7:0] b);
    return b == PAD_SPACE || b == PAD_SHIFTED;
  endfunction

  task automatic predict_host_name(input logic ext_en, input logic [23:0] ext);
    int first;
    int stop;
    first = 0;
    while (first < NAME_LEN && pad_byte(name_bytes[first])) first++;
    stop = NAME_LEN;
    while (stop > first && pad_byte(name_bytes[stop - 1])) stop--;
    for (int i = first; i < stop; i++) begin
      host_chars_q.push_back('{filtered_char(name_bytes[i], windows_rules), 1'b0});
    end
    if (ext_en && ext[23:16] != 8'h00) begin
      host_chars_q.push_back('{OUT_DOT, 1'b0});
      host_chars_q.push_back('{ext[22:16], 1'b0});
      host_chars_q.push_back('{ext[14:8], 1'b0});
      host_chars_q.push_back('{ext[6:0], 1'b0});
    end
    host_chars_q.push_back('{OUT_TERM, 1'b1});
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    host_beat_t want;
    if (!rst_n) begin
      bytes_loaded  = 0;
      windows_rules = 1'b0;
      host_chars_q.delete();
    end else begin
      if (cfg_wr_en) begin
        windows_rules = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        name_bytes[bytes_loaded] = in_name_byte;
        bytes_loaded++;
        if (bytes_loaded == NAME_LEN) begin
          predict_host_name(in_ext_enable, in_ext_chars);
          bytes_loaded = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (host_chars_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char %h last %b", out_char, out_last));
        end else begin
          want = host_chars_q.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("char %h, expected %h", out_char, want.ch));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
          end
          chars_checked++;
        end
      end
    end
    chars_pending <= host_chars_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the PETSCII file name converter testbench: clock, reset, name and
// register stimulus, receiver back-pressure and the verdict.
// Depends on pfh_pkg, pfh_in_if, pfh_out_if, the converter and tb_pfh_checker.
module tb_top;
  import pfh_pkg::*;

  localparam int NAME_LEN       = 16;
  localparam int RAND_NAMES     = 22;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] SPECIAL_PET [27] = '{
    8'h20, 8'ha0, 8'h2f, 8'h5c, 8'h3f, 8'h25, 8'h2a, 8'h3a, 8'h22,
    8'h3c, 8'h3e, 8'h7c, 8'h00, 8'hff, 8'hdb, 8'hdf, 8'he0, 8'hc0,
    8'h03, 8'h08, 8'h09, 8'h14, 8'h8d, 8'h41, 8'h5a, 8'h60, 8'h7f
  };
  localparam logic [7:0] DIRECTED_NAME [NAME_LEN] = '{
    8'ha0, 8'h20, 8'h00, 8'hff, 8'h2f, 8'h20, 8'ha0, 8'h5c,
    8'hdb, 8'he0, 8'h41, 8'hc1, 8'h7f, 8'h8d, 8'h20, 8'ha0
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic idle_on;
  logic hold_now;
  int   mismatches;
  int   chars_pending;
  int   chars_checked;
  int   names_sent;
  int   stall_cycles;

  pfh_in_if  in_ch ();
  pfh_out_if out_ch ();

  petscii_filename_to_host_top #(
    .NAME_LEN(NAME_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tb_pfh_checker #(
    .NAME_LEN(NAME_LEN)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_name_byte (in_ch.name_byte),
    .in_ext_enable(in_ch.ext_enable),
    .in_ext_chars (in_ch.ext_chars),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_char     (out_ch.out_char),
    .out_last     (out_ch.out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a beat.", stall_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_now = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_name_byte();
    if ($urandom_range(0, 2) == 0) begin
      return SPECIAL_PET[$urandom_range(0, 26)];
    end
    return 8'($urandom);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic ext_en, input logic [23:0] ext);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.name_byte <= 8'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.name_byte  <= b;
    in_ch.ext_enable <= ext_en;
    in_ch.ext_chars  <= ext;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_host_rules(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int          lead;
    int          trail;
    int          shape;
    logic [7:0]  b;
    logic [23:0] ext;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    idle_on          = 1'b1;
    hold_now         = 1'b0;
    names_sent       = 0;
    stall_cycles     = 0;
    in_ch.valid      = 1'b0;
    in_ch.name_byte  = 8'h00;
    in_ch.ext_enable = 1'b0;
    in_ch.ext_chars  = 24'h000000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_host_rules(1'b0);

    for (int i = 0; i < NAME_LEN; i++) begin
      send_beat(DIRECTED_NAME[i], 1'b1, (i == NAME_LEN - 1) ? 24'hff0080 : 24'h000000);
    end
    names_sent++;

    for (int n = 0; n < RAND_NAMES; n++) begin
      if (n % 6 == 0) begin
        wait_all_results();
        write_host_rules((n / 6) % 2 == 0);
      end
      if (n == 3) begin
        hold_now = 1'b1;
      end
      if (n == 9) begin
        wait_all_results();
      end
      if (n >= 18) begin
        idle_on = 1'b0;
      end
      shape = $urandom_range(0, 9);
      lead  = $urandom_range(0, 4);
      trail = $urandom_range(0, 4);
      for (int i = 0; i < NAME_LEN; i++) begin
        if (shape == 0 || i < lead || i >= NAME_LEN - trail) begin
          b = $urandom_range(0, 1) ? PAD_SPACE : PAD_SHIFTED;
        end else begin
          b = pick_name_byte();
        end
        ext = 24'($urandom);
        if (i == NAME_LEN - 1) begin
          case ($urandom_range(0, 4))
            0: ext[23:16] = 8'h00;
            1: ext[15:8]  = 8'h00;
            2: ext[7:0]   = 8'h00;
            default: ;
          endcase
        end
        send_beat(b, 1'($urandom), ext);
      end
      names_sent++;
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (30) @(posedge clk);
    $display("Converted %0d names (%0d name bytes) under both host rule sets, %0d chars checked.",
             names_sent, names_sent * NAME_LEN, chars_checked);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
